// ===== design/ascii_command_encoder_assert.svh =====
// Assertion macros for the ASCII command encoder.
// Expects signals named clock and reset in the including scope.
`ifndef ASCII_COMMAND_ENCODER_ASSERT_SVH
`define ASCII_COMMAND_ENCODER_ASSERT_SVH

// Property must hold in the same cycle.
`define ACE_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ace_pkg.sv =====
// Shared types, codes and helpers for the ASCII command encoder.
// No dependencies; imported by every design file but the .svh.
package ace_pkg;

   typedef logic [7:0] char_type;
   typedef logic [2:0] kind_type;

   // Request kinds
   localparam kind_type KIND_MODE   = 3'd0;
   localparam kind_type KIND_POWER  = 3'd1;
   localparam kind_type KIND_BRIGHT = 3'd2;
   localparam kind_type KIND_SPEED  = 3'd3;
   localparam kind_type KIND_COLOR  = 3'd4;
   localparam kind_type KIND_ALARM  = 3'd5;

   // Range limits on value_a
   localparam logic [7:0] MODE_MAX  = 8'd10;
   localparam logic [7:0] LEVEL_MAX = 8'd15;
   localparam logic [7:0] STEP_MAX  = 8'd4;

   // ASCII codes
   localparam char_type CHAR_ZERO = 8'h30;
   localparam char_type CHAR_A    = 8'h41;
   localparam char_type CHAR_B    = 8'h42;
   localparam char_type CHAR_C    = 8'h43;
   localparam char_type CHAR_D    = 8'h44;
   localparam char_type CHAR_E    = 8'h45;
   localparam char_type CHAR_F    = 8'h46;

   // Longest command: letter plus three 3-digit values
   localparam int FRAME_LEN = 10;
   localparam int CNT_W     = $clog2(FRAME_LEN + 1);

   typedef logic [CNT_W-1:0] cnt_type;

   // Three decimal digits of one 8-bit value
   typedef struct packed {
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
   } bcd_type;

   // Merge stage status toward the top level
   typedef struct packed {
      logic load;
      logic busy;
   } mrg_stat_type;

   function automatic char_type digit_char(input logic [3:0] d);
      return CHAR_ZERO + {4'd0, d};
   endfunction

endpackage

// ===== design/ace_if.sv =====
// Request and response channel interfaces for the ASCII command encoder.
// Depends on ace_pkg for the payload types.
interface ace_req_if import ace_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type req_type;
   logic [7:0] value_a;
   logic [7:0] value_b;
   logic [7:0] value_c;

   modport source (output valid, req_type, value_a, value_b, value_c, input ready);
   modport sink   (input valid, req_type, value_a, value_b, value_c, output ready);
endinterface

interface ace_rsp_if import ace_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type out_byte;
   logic     last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== design/ace_lane.sv =====
// One conversion lane: registers the three decimal digits of an 8-bit value.
// Depends on ace_pkg.
module ace_lane import ace_pkg::*; (
   input  logic       clock,
   input  logic       enable,
   input  logic [7:0] value,
   output bcd_type    digits
);

   logic [1:0]  hund;
   logic [7:0]  hund_sub;
   logic [7:0]  rem8;
   logic [6:0]  rem7;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [6:0]  ones7;
   bcd_type     digits_in;
   bcd_type     digits_ff;

   // Hundreds by two compares, remainder below 100
   always_comb begin
      if (value >= 8'd200) begin
         hund     = 2'd2;
         hund_sub = 8'd200;
      end else if (value >= 8'd100) begin
         hund     = 2'd1;
         hund_sub = 8'd100;
      end else begin
         hund     = 2'd0;
         hund_sub = 8'd0;
      end
   end

   assign rem8 = value - hund_sub;
   assign rem7 = rem8[6:0];

   // Tens by reciprocal multiply: (n * 205) >> 11 equals n / 10 for n < 100
   assign prod     = 15'(rem7) * 15'd205;
   assign tens     = prod[14:11];
   assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
   assign ones7    = rem7 - tens_x10;

   assign digits_in.hund = {2'b00, hund};
   assign digits_in.tens = tens;
   assign digits_in.ones = ones7[3:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         digits_ff <= digits_in;
      end
   end

   assign digits = digits_ff;

endmodule

// ===== design/ace_merge.sv =====
// Merge stage (uses ace_pkg): assembles command bytes from the lane digits
// and shifts them out via the response register, one per cycle when ready.
module ace_merge import ace_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  kind_type     in_kind,
   input  bcd_type      dig_a,
   input  bcd_type      dig_b,
   input  bcd_type      dig_c,
   output mrg_stat_type stat,
   ace_rsp_if.source    rsp_ch
);

   char_type frame_ff [FRAME_LEN];
   char_type frame_in [FRAME_LEN];
   char_type build    [FRAME_LEN];
   cnt_type  build_len;
   cnt_type  rem_ff;
   cnt_type  rem_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   char_type rsp_byte_ff;
   char_type rsp_byte_in;
   logic     rsp_last_ff;
   logic     rsp_last_in;
   logic     out_adv;
   logic     emit;
   logic     load;

   // Build the byte frame for the waiting command
   always_comb begin
      for (int i = 0; i < FRAME_LEN; i++) begin
         build[i] = CHAR_ZERO;
      end
      build_len = '0;
      unique case (in_kind)
         KIND_MODE, KIND_BRIGHT, KIND_SPEED: begin
            build[0]  = (in_kind == KIND_MODE)   ? CHAR_A :
                        (in_kind == KIND_BRIGHT) ? CHAR_E : CHAR_F;
            build[1]  = digit_char(dig_a.tens);
            build[2]  = digit_char(dig_a.ones);
            build_len = CNT_W'(3);
         end
         KIND_POWER, KIND_ALARM: begin
            build[0]  = (in_kind == KIND_POWER) ? CHAR_B : CHAR_D;
            build[1]  = digit_char(dig_a.ones);
            build_len = CNT_W'(2);
         end
         KIND_COLOR: begin
            build[0]  = CHAR_C;
            build[1]  = digit_char(dig_a.hund);
            build[2]  = digit_char(dig_a.tens);
            build[3]  = digit_char(dig_a.ones);
            build[4]  = digit_char(dig_b.hund);
            build[5]  = digit_char(dig_b.tens);
            build[6]  = digit_char(dig_b.ones);
            build[7]  = digit_char(dig_c.hund);
            build[8]  = digit_char(dig_c.tens);
            build[9]  = digit_char(dig_c.ones);
            build_len = CNT_W'(FRAME_LEN);
         end
         default: begin
            build_len = '0;
         end
      endcase
   end

   // Handshake: emit head byte when the response register frees up;
   // a new frame loads when idle or as the last byte leaves
   assign out_adv = !rsp_valid_ff || rsp_ch.ready;
   assign emit    = (rem_ff != '0) && out_adv;
   assign load    = in_valid && ((rem_ff == '0) || (emit && (rem_ff == CNT_W'(1))));

   always_comb begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         frame_in[i] = emit ? frame_ff[i+1] : frame_ff[i];
      end
      frame_in[FRAME_LEN-1] = frame_ff[FRAME_LEN-1];
      rem_in       = emit ? rem_ff - CNT_W'(1) : rem_ff;
      rsp_valid_in = out_adv ? emit : rsp_valid_ff;
      rsp_byte_in  = emit ? frame_ff[0] : rsp_byte_ff;
      rsp_last_in  = emit ? (rem_ff == CNT_W'(1)) : rsp_last_ff;
      if (load) begin
         frame_in = build;
         rem_in   = build_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_byte  = rsp_byte_ff;
   assign rsp_ch.last_byte = rsp_last_ff;

   assign stat.load = load;
   assign stat.busy = (rem_ff != '0);

endmodule

// ===== design/ascii_command_encoder.sv =====
// ASCII command encoder. Each request transaction (kind plus up to three
// 8-bit values) becomes a letter followed by decimal digits, one byte per
// response transaction, the final byte flagged by last_byte; out-of-range
// values and unused kinds produce no bytes. Three conversion lanes split
// value_a/b/c into digits in parallel, then a merge stage shifts the bytes
// out. A command occupies the output for its byte count: 2 bytes for power
// and alarm, 3 for mode, brightness and speed, 10 for colour; the next
// command loads in the cycle its predecessor's last byte enters the output
// register, so that one-byte-per-cycle register sets the throughput while
// ready is high. A command passes lane, frame and output registers in order.
module ascii_command_encoder import ace_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ace_req_if.sink   req_ch,
   ace_rsp_if.source rsp_ch
);

`include "ascii_command_encoder_assert.svh"

   logic         s1_valid_ff;
   logic         s1_valid_in;
   kind_type     s1_kind_ff;
   logic         s1_ready;
   logic         req_good;
   logic         req_take;
   bcd_type      dig_a;
   bcd_type      dig_b;
   bcd_type      dig_c;
   mrg_stat_type stat;

   // Range check on the incoming request
   always_comb begin
      unique case (req_ch.req_type)
         KIND_MODE:              req_good = (req_ch.value_a <= MODE_MAX);
         KIND_POWER, KIND_ALARM: req_good = (req_ch.value_a <= STEP_MAX);
         KIND_BRIGHT, KIND_SPEED: req_good = (req_ch.value_a <= LEVEL_MAX);
         KIND_COLOR:             req_good = 1'b1;
         default:                req_good = 1'b0;
      endcase
   end

   // Lane stage advances when empty or when the merge stage takes its item
   assign s1_ready     = !s1_valid_ff || stat.load;
   assign req_ch.ready = s1_ready;
   assign req_take     = req_ch.valid && s1_ready;
   assign s1_valid_in  = s1_ready ? (req_take && req_good) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_kind_ff <= req_ch.req_type;
      end
   end

   // Digit lanes, one per value
   ace_lane u_lane_a (
      .clock  (clock),
      .enable (s1_ready),
      .value  (req_ch.value_a),
      .digits (dig_a)
   );

   ace_lane u_lane_b (
      .clock  (clock),
      .enable (s1_ready),
      .value  (req_ch.value_b),
      .digits (dig_b)
   );

   ace_lane u_lane_c (
      .clock  (clock),
      .enable (s1_ready),
      .value  (req_ch.value_c),
      .digits (dig_c)
   );

   ace_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_kind  (s1_kind_ff),
      .dig_a    (dig_a),
      .dig_b    (dig_b),
      .dig_c    (dig_c),
      .stat     (stat),
      .rsp_ch   (rsp_ch)
   );

   // Checks
   `ACE_ASSERT(a_stall_has_item, !req_ch.ready |-> s1_valid_ff, "request stalled with empty lane stage")
   `ACE_ASSERT_NEXT(a_load_busy, stat.load, stat.busy, "frame load left merge stage idle")
   `ACE_ASSERT_NEXT(a_idle_drains, rsp_ch.valid && rsp_ch.ready && !stat.busy, !rsp_ch.valid, "byte emitted with no frame pending")

endmodule

// ===== tb/tb_ascii_command_encoder.sv =====
// Self-checking testbench for the ASCII command encoder: directed and random commands
// are driven on the request channel, and the bytes are checked against a local encoder.
// Depends on ace_pkg, ace_if.sv and ascii_command_encoder.sv.
`timescale 1ns / 1ps

module tb_ascii_command_encoder;
   import ace_pkg::*;

   // Kinds the block has no command for
   localparam kind_type KIND_SPARE_6 = 3'd6;
   localparam kind_type KIND_SPARE_7 = 3'd7;

   localparam int IDLE_PCT      = 26;
   localparam int RANDOM_CMDS   = 110;
   localparam int STEADY_FIRST  = 80;
   localparam int STEADY_LAST   = 120;
   localparam int TAIL_CYCLES   = 30;

   // One command request; hold_for_drain keeps it back until all bytes are in
   typedef struct {
      kind_type   kind;
      logic [7:0] val_a;
      logic [7:0] val_b;
      logic [7:0] val_c;
      bit         hold_for_drain;
   } command_type;

   typedef struct packed {
      char_type code;
      logic     last;
   } cmd_byte_type;

   logic clock;
   logic reset;

   ace_req_if req_bus ();
   ace_rsp_if rsp_bus ();

   command_type  pending_cmds[$];
   cmd_byte_type expected_bytes[$];
   command_type  next_cmd;
   cmd_byte_type want_byte;
   logic         req_taken;
   int           accepted_cmds;
   int           error_count;
   logic         steady;

   ascii_command_encoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // No idling on either side while this window of commands goes through
   assign steady = (accepted_cmds >= STEADY_FIRST) && (accepted_cmds < STEADY_LAST);

   // Highest value_a a kind accepts; colour takes the full range
   function automatic logic [7:0] value_limit(input kind_type kind);
      case (kind)
         KIND_MODE:               return MODE_MAX;
         KIND_POWER, KIND_ALARM:  return STEP_MAX;
         KIND_BRIGHT, KIND_SPEED: return LEVEL_MAX;
         default:                 return 8'd255;
      endcase
   endfunction

   function automatic void push_char(input char_type code);
      cmd_byte_type b;
      b.code = code;
      b.last = 1'b0;
      expected_bytes.push_back(b);
   endfunction

   function automatic void push_decimal3(input logic [7:0] v);
      push_char(CHAR_ZERO + char_type'(v / 8'd100));
      push_char(CHAR_ZERO + char_type'((v / 8'd10) % 8'd10));
      push_char(CHAR_ZERO + char_type'(v % 8'd10));
   endfunction

   // Encode one accepted command into the queue of expected bytes
   function automatic void encode_command(input kind_type kind, input logic [7:0] va,
                                          input logic [7:0] vb, input logic [7:0] vc);
      int before_cnt;
      before_cnt = expected_bytes.size();
      case (kind)
         KIND_MODE, KIND_BRIGHT, KIND_SPEED: begin
            if (va <= value_limit(kind)) begin
               if (kind == KIND_MODE)
                  push_char(CHAR_A);
               else if (kind == KIND_BRIGHT)
                  push_char(CHAR_E);
               else
                  push_char(CHAR_F);
               push_char(CHAR_ZERO + char_type'(va / 8'd10));
               push_char(CHAR_ZERO + char_type'(va % 8'd10));
            end
         end
         KIND_POWER, KIND_ALARM: begin
            if (va <= STEP_MAX) begin
               push_char((kind == KIND_POWER) ? CHAR_B : CHAR_D);
               push_char(CHAR_ZERO + va);
            end
         end
         KIND_COLOR: begin
            push_char(CHAR_C);
            push_decimal3(va);
            push_decimal3(vb);
            push_decimal3(vc);
         end
         default: ;
      endcase
      if (expected_bytes.size() > before_cnt)
         expected_bytes[$].last = 1'b1;
   endfunction

   function automatic void add_command(input kind_type kind, input logic [7:0] va,
                                       input logic [7:0] vb, input logic [7:0] vc,
                                       input bit drain);
      command_type c;
      c.kind = kind;
      c.val_a = va;
      c.val_b = vb;
      c.val_c = vc;
      c.hold_for_drain = drain;
      pending_cmds.push_back(c);
   endfunction

   // Request driver: a new transaction once the previous one has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_cmds.size() > 0
             && !(pending_cmds[0].hold_for_drain && expected_bytes.size() > 0)
             && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_cmd = pending_cmds.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.req_type <= next_cmd.kind;
            req_bus.value_a  <= next_cmd.val_a;
            req_bus.value_b  <= next_cmd.val_b;
            req_bus.value_c  <= next_cmd.val_c;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response backpressure
   always @(negedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Monitor: check each byte against the oldest expectation, predict on acceptance
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected byte, expected none, actual %h last %b",
                        $time, rsp_bus.out_byte, rsp_bus.last_byte);
               error_count++;
            end else begin
               want_byte = expected_bytes.pop_front();
               if (rsp_bus.out_byte !== want_byte.code) begin
                  $display("%0t: out_byte expected %h, actual %h",
                           $time, want_byte.code, rsp_bus.out_byte);
                  error_count++;
               end
               if (rsp_bus.last_byte !== want_byte.last) begin
                  $display("%0t: last_byte expected %b, actual %b",
                           $time, want_byte.last, rsp_bus.last_byte);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            encode_command(req_bus.req_type, req_bus.value_a, req_bus.value_b,
                           req_bus.value_c);
            accepted_cmds <= accepted_cmds + 1;
         end
      end
   end

   // Stimulus, reset and end of test
   initial begin : stimulus
      int made;
      kind_type kind;
      logic [7:0] lim;
      logic [7:0] va;
      error_count      = 0;
      accepted_cmds    = 0;
      req_taken        = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = KIND_MODE;
      req_bus.value_a  = 8'd0;
      req_bus.value_b  = 8'd0;
      req_bus.value_c  = 8'd0;
      rsp_bus.ready    = 1'b0;

      // Directed: range edges of every kind, colour extremes, unused kinds
      add_command(KIND_MODE,    8'd0,   8'd0,   8'd0,   1'b0);
      add_command(KIND_MODE,    8'd10,  8'd255, 8'd255, 1'b0);
      add_command(KIND_MODE,    8'd11,  8'd0,   8'd0,   1'b0);
      add_command(KIND_MODE,    8'd255, 8'd0,   8'd0,   1'b0);
      add_command(KIND_POWER,   8'd0,   8'd0,   8'd0,   1'b0);
      add_command(KIND_POWER,   8'd4,   8'd0,   8'd0,   1'b0);
      add_command(KIND_POWER,   8'd5,   8'd0,   8'd0,   1'b0);
      add_command(KIND_BRIGHT,  8'd0,   8'd0,   8'd0,   1'b0);
      add_command(KIND_BRIGHT,  8'd15,  8'd0,   8'd0,   1'b0);
      add_command(KIND_BRIGHT,  8'd16,  8'd0,   8'd0,   1'b0);
      add_command(KIND_SPEED,   8'd0,   8'd0,   8'd0,   1'b0);
      add_command(KIND_SPEED,   8'd15,  8'd0,   8'd0,   1'b0);
      add_command(KIND_SPEED,   8'd16,  8'd0,   8'd0,   1'b0);
      add_command(KIND_COLOR,   8'd0,   8'd0,   8'd0,   1'b0);
      add_command(KIND_COLOR,   8'd255, 8'd255, 8'd255, 1'b0);
      add_command(KIND_COLOR,   8'd100, 8'd99,  8'd9,   1'b0);
      add_command(KIND_COLOR,   8'd170, 8'd85,  8'd200, 1'b0);
      add_command(KIND_ALARM,   8'd0,   8'd0,   8'd0,   1'b0);
      add_command(KIND_ALARM,   8'd4,   8'd0,   8'd0,   1'b0);
      add_command(KIND_ALARM,   8'd5,   8'd0,   8'd0,   1'b0);
      add_command(KIND_SPARE_6, 8'd3,   8'd0,   8'd0,   1'b0);
      add_command(KIND_SPARE_7, 8'd255, 8'd255, 8'd255, 1'b0);

      // Random: mostly valid commands, some out-of-range values and unused kinds
      made = 0;
      while (made < RANDOM_CMDS) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(3) == 0) begin
               kind = $urandom_range(1) ? KIND_SPARE_7 : KIND_SPARE_6;
               va = 8'($urandom_range(255));
            end else begin
               kind = kind_type'($urandom_range(3));
               if (kind == KIND_SPEED && $urandom_range(1))
                  kind = KIND_ALARM;
               lim = value_limit(kind);
               va = 8'($urandom_range(255, lim + 1));
            end
            add_command(kind, va, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
         end else begin
            kind = kind_type'($urandom_range(5));
            lim = value_limit(kind);
            va = 8'($urandom_range(lim));
            add_command(kind, va, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        (made % 50) == 25);
            made++;
         end
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Wait for the request queue to empty, then for every byte to arrive
      @(negedge clock);
      while (pending_cmds.size() > 0 || (req_bus.valid && !req_taken))
         @(negedge clock);
      @(negedge clock);
      while (expected_bytes.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
